// ----- src/interval_constant_fold_unit_macros.svh -----
// Assertion macros for the interval constant fold unit.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef INTERVAL_CONSTANT_FOLD_UNIT_MACROS_SVH
`define INTERVAL_CONSTANT_FOLD_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ICFU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ICFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/icfu_pkg.sv -----
// Shared types, opcodes and pipeline constants for the interval constant fold unit.
// No dependencies.
`default_nettype none
package icfu_pkg;

    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
    localparam int unsigned MUL_LAT   = 4;
    localparam int unsigned CORE_LAT  = DIV_LAT;
    localparam int unsigned MUL_PAD   = CORE_LAT - MUL_LAT;

    localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

    typedef enum logic [3:0] {
        OP_ADD = 4'd0,  OP_SUB = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
        OP_MOD = 4'd4,  OP_AND = 4'd5,  OP_OR  = 4'd6,  OP_XOR = 4'd7,
        OP_SHL = 4'd8,  OP_SAR = 4'd9,  OP_EQ  = 4'd10, OP_NE  = 4'd11,
        OP_LT  = 4'd12, OP_LE  = 4'd13, OP_GT  = 4'd14, OP_GE  = 4'd15
    } t_op;

    typedef struct packed {
        t_op                opcode;
        logic               a_known;
        logic signed [63:0] a_value;
        logic               a_has_range;
        logic signed [63:0] a_min;
        logic signed [63:0] a_max;
        logic               b_known;
        logic signed [63:0] b_value;
        logic               b_has_range;
        logic signed [63:0] b_min;
        logic signed [63:0] b_max;
    } t_in;

    typedef struct packed {
        logic               value_known;
        logic signed [63:0] result_value;
        logic               range_valid;
        logic signed [63:0] range_min;
        logic signed [63:0] range_max;
    } t_out;

    function automatic logic [63:0] f_abs(input logic signed [63:0] x);
        f_abs = x[63] ? (64'd0 - 64'(x)) : 64'(x);
    endfunction

endpackage
`default_nettype wire

// ----- src/icfu_mul.sv -----
// Pipelined signed 64x64 multiplier from 32x32 partial products, with overflow flag.
// Depends on icfu_pkg; the result passes through a MUL_PAD-deep delay line after the product.
`default_nettype none
module icfu_mul
    import icfu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    output logic signed [63:0]      o_prod,
    output logic                    o_ovf
);

    logic [63:0]  r_ua, r_ub;
    logic         r_neg1, r_neg2, r_neg3, r_neg4;
    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic [64:0]  r_mid;
    logic [63:0]  r_ll3, r_hh3;
    logic [127:0] r_p;
    logic [64:0]  r_pd [MUL_PAD];
    logic [64:0]  n_res;

    always_comb begin
        n_res[63:0] = r_neg4 ? (64'd0 - r_p[63:0]) : r_p[63:0];
        n_res[64]   = (r_p[127:64] != 64'd0)
                    || (r_neg4 ? (r_p[63] && (r_p[62:0] != 63'd0)) : r_p[63]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ua   <= f_abs(i_a);
            r_ub   <= f_abs(i_b);
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ll   <= r_ua[31:0]  * r_ub[31:0];
            r_lh   <= r_ua[31:0]  * r_ub[63:32];
            r_hl   <= r_ua[63:32] * r_ub[31:0];
            r_hh   <= r_ua[63:32] * r_ub[63:32];
            r_neg2 <= r_neg1;
            r_mid  <= {1'b0, r_lh} + {1'b0, r_hl};
            r_ll3  <= r_ll;
            r_hh3  <= r_hh;
            r_neg3 <= r_neg2;
            r_p    <= {r_hh3, r_ll3} + {31'd0, r_mid, 32'd0};
            r_neg4 <= r_neg3;
            r_pd[0] <= n_res;
            for (int k = 1; k < MUL_PAD; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
        end
    end

    assign o_prod = r_pd[MUL_PAD-1][63:0];
    assign o_ovf  = r_pd[MUL_PAD-1][64];

endmodule
`default_nettype wire

// ----- src/icfu_div.sv -----
// Pipelined signed 64-bit restoring divider, one quotient bit per stage.
// Depends on icfu_pkg; quotient and remainder truncate toward zero.
`default_nettype none
module icfu_div
    import icfu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    output logic signed [63:0]      o_quo,
    output logic signed [63:0]      o_rem
);

    logic [63:0] r_rem [DIV_STEPS+1];
    logic [63:0] r_nq  [DIV_STEPS+1];
    logic [63:0] r_d   [DIV_STEPS+1];
    logic        r_sq  [DIV_STEPS+1];
    logic        r_sr  [DIV_STEPS+1];
    logic [63:0] r_quo_o, r_rem_o;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 64'd0;
            r_nq[0]  <= f_abs(i_a);
            r_d[0]   <= f_abs(i_b);
            r_sq[0]  <= i_a[63] ^ i_b[63];
            r_sr[0]  <= i_a[63];
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [64:0] t;
        logic [64:0] diff;
        logic        ge;
        always_comb begin
            t    = {r_rem[k-1], r_nq[k-1][63]};
            diff = t - {1'b0, r_d[k-1]};
            ge   = (t >= {1'b0, r_d[k-1]});
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? diff[63:0] : t[63:0];
                r_nq[k]  <= {r_nq[k-1][62:0], ge};
                r_d[k]   <= r_d[k-1];
                r_sq[k]  <= r_sq[k-1];
                r_sr[k]  <= r_sr[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo_o <= r_sq[DIV_STEPS] ? (64'd0 - r_nq[DIV_STEPS]) : r_nq[DIV_STEPS];
            r_rem_o <= r_sr[DIV_STEPS] ? (64'd0 - r_rem[DIV_STEPS]) : r_rem[DIV_STEPS];
        end
    end

    assign o_quo = r_quo_o;
    assign o_rem = r_rem_o;

endmodule
`default_nettype wire

// ----- src/interval_constant_fold_unit.sv -----
// Interval constant fold unit: folds one 64-bit integer operation on two operand
// facts to a constant, or derives a result range. Takes one transaction per cycle
// while the output is not stalled; o_valid rises after the input register, the
// 66-stage divider pipeline (operand, 64 quotient-bit and sign stages), and the
// combine and output registers. The whole pipeline holds while a result waits at
// the output.
// Depends on icfu_pkg, icfu_mul, icfu_div and interval_constant_fold_unit_macros.svh.
`default_nettype none
`include "interval_constant_fold_unit_macros.svh"
module interval_constant_fold_unit
    import icfu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_in  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out      o_data
);

    typedef struct packed {
        t_op                op;
        logic               fold_ok;
        logic signed [63:0] e_val;
        logic               e_rv;
        logic signed [63:0] e_lo;
        logic signed [63:0] e_hi;
        logic               mul_pre;
        logic               div_pre;
    } t_side;

    typedef struct packed {
        logic               vk;
        logic signed [63:0] val;
        logic               use_span;
        logic               span_ok;
        logic               e_ok;
        logic signed [63:0] e_lo;
        logic signed [63:0] e_hi;
        logic signed [63:0] min01;
        logic signed [63:0] max01;
        logic signed [63:0] min23;
        logic signed [63:0] max23;
    } t_pst;

    logic  en;
    t_in   r_in;
    logic  r_iv;
    t_side r_sd [CORE_LAT];
    logic  r_vl [CORE_LAT];
    t_pst  r_p;
    logic  r_pv;
    t_out  r_out;
    logic  r_ov;
    t_side n_sd;
    t_pst  n_p;
    t_out  n_out;

    logic signed [63:0] ua [4];
    logic signed [63:0] ub [4];
    logic signed [63:0] prod [4];
    logic signed [63:0] quo [4];
    logic signed [63:0] rmd [4];
    logic [3:0]         ovf;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // Side path: fold value and range rules that need no multiplier or divider.
    always_comb begin
        logic signed [63:0] av, bv, alo, ahi, blo, bhi;
        logic               kk, rb, sh_ok;
        logic [5:0]         s;
        logic signed [63:0] sum_l, sum_h, dif_l, dif_h, chk_h, m;
        av  = r_in.a_value;  bv  = r_in.b_value;
        alo = r_in.a_min;    ahi = r_in.a_max;
        blo = r_in.b_min;    bhi = r_in.b_max;
        kk    = r_in.a_known && r_in.b_known;
        rb    = r_in.a_has_range && r_in.b_has_range;
        sh_ok = (bv[63:6] == 58'd0);
        s     = bv[5:0];
        sum_l = alo + blo;
        sum_h = ahi + bhi;
        dif_l = alo - bhi;
        dif_h = ahi - blo;
        chk_h = ahi >>> (6'd63 - s);
        m     = ahi | bhi;
        if (r_in.opcode != OP_AND) begin
            m = m | (m >>> 1);
            m = m | (m >>> 2);
            m = m | (m >>> 4);
            m = m | (m >>> 8);
            m = m | (m >>> 16);
            m = m | (m >>> 32);
        end

        n_sd         = '0;
        n_sd.op      = r_in.opcode;
        n_sd.mul_pre = rb;
        n_sd.div_pre = rb && !(blo <= 0 && bhi >= 0) && (blo != 0) && (bhi != 0)
                     && !((alo == S64_MIN || ahi == S64_MIN)
                          && (blo == -64'sd1 || bhi == -64'sd1));

        if (r_in.opcode inside {OP_DIV, OP_MOD}) begin
            n_sd.fold_ok = kk && (bv != 0) && !(av == S64_MIN && bv == -64'sd1);
        end else if (r_in.opcode inside {OP_SHL, OP_SAR}) begin
            n_sd.fold_ok = kk && sh_ok;
        end else begin
            n_sd.fold_ok = kk;
        end

        case (r_in.opcode)
            OP_ADD:  n_sd.e_val = av + bv;
            OP_SUB:  n_sd.e_val = av - bv;
            OP_AND:  n_sd.e_val = av & bv;
            OP_OR:   n_sd.e_val = av | bv;
            OP_XOR:  n_sd.e_val = av ^ bv;
            OP_SHL:  n_sd.e_val = av << s;
            OP_SAR:  n_sd.e_val = av >>> s;
            OP_EQ:   n_sd.e_val = {63'd0, av == bv};
            OP_NE:   n_sd.e_val = {63'd0, av != bv};
            OP_LT:   n_sd.e_val = {63'd0, av < bv};
            OP_LE:   n_sd.e_val = {63'd0, av <= bv};
            OP_GT:   n_sd.e_val = {63'd0, av > bv};
            OP_GE:   n_sd.e_val = {63'd0, av >= bv};
            default: n_sd.e_val = '0;
        endcase

        if (r_in.opcode inside {[OP_EQ:OP_GE]}) begin
            n_sd.e_rv = 1'b1;
            n_sd.e_hi = 64'sd1;
        end else if (r_in.opcode == OP_AND && r_in.b_known && !bv[63]) begin
            n_sd.e_rv = 1'b1;
            n_sd.e_hi = bv;
        end else if (r_in.opcode == OP_AND && r_in.a_known && !av[63]) begin
            n_sd.e_rv = 1'b1;
            n_sd.e_hi = av;
        end else begin
            case (r_in.opcode)
                OP_ADD: begin
                    n_sd.e_rv = rb
                        && !((alo[63] == blo[63]) && (sum_l[63] != alo[63]))
                        && !((ahi[63] == bhi[63]) && (sum_h[63] != ahi[63]));
                    n_sd.e_lo = sum_l;
                    n_sd.e_hi = sum_h;
                end
                OP_SUB: begin
                    n_sd.e_rv = rb
                        && !((alo[63] != bhi[63]) && (dif_l[63] != alo[63]))
                        && !((ahi[63] != blo[63]) && (dif_h[63] != ahi[63]));
                    n_sd.e_lo = dif_l;
                    n_sd.e_hi = dif_h;
                end
                OP_MOD: begin
                    n_sd.e_rv = rb && r_in.b_known && (bv != 0) && (bv != S64_MIN);
                    n_sd.e_hi = (bv[63] ? -bv : bv) - 64'sd1;
                    n_sd.e_lo = alo[63] ? -n_sd.e_hi : 64'sd0;
                    if (ahi <= 0) begin
                        n_sd.e_hi = '0;
                    end
                end
                OP_SHL: begin
                    n_sd.e_rv = rb && r_in.b_known && sh_ok && (s != 6'd63) && !alo[63]
                        && ((alo >>> (6'd63 - s)) == 64'sd0)
                        && (chk_h == 64'sd0 || chk_h == -64'sd1);
                    n_sd.e_lo = alo << s;
                    n_sd.e_hi = ahi << s;
                end
                OP_SAR: begin
                    n_sd.e_rv = rb && r_in.b_known && sh_ok;
                    n_sd.e_lo = alo >>> s;
                    n_sd.e_hi = ahi >>> s;
                end
                OP_AND, OP_OR, OP_XOR: begin
                    n_sd.e_rv = rb && !alo[63] && !blo[63];
                    n_sd.e_hi = m;
                end
                default: n_sd.e_rv = 1'b0;
            endcase
        end
    end

    // Lane 0 carries the constant operands when folding goes ahead.
    always_comb begin
        ua[0] = n_sd.fold_ok ? r_in.a_value : r_in.a_min;
        ub[0] = n_sd.fold_ok ? r_in.b_value : r_in.b_min;
        ua[1] = r_in.a_min;  ub[1] = r_in.b_max;
        ua[2] = r_in.a_max;  ub[2] = r_in.b_min;
        ua[3] = r_in.a_max;  ub[3] = r_in.b_max;
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        icfu_mul u_mul (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_a    (ua[g]),
            .i_b    (ub[g]),
            .o_prod (prod[g]),
            .o_ovf  (ovf[g])
        );
        icfu_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (ua[g]),
            .i_b   (ub[g]),
            .o_quo (quo[g]),
            .o_rem (rmd[g])
        );
    end

    // Combine stage: selects the folded value and flags, and forms the first level of the endpoint span.
    always_comb begin
        t_side              sd;
        logic signed [63:0] c [4];
        sd = r_sd[CORE_LAT-1];
        for (int k = 0; k < 4; k++) begin
            c[k] = (sd.op == OP_MUL) ? prod[k] : quo[k];
        end
        n_p.vk = sd.fold_ok;
        case (sd.op)
            OP_MUL:  n_p.val = prod[0];
            OP_DIV:  n_p.val = quo[0];
            OP_MOD:  n_p.val = rmd[0];
            default: n_p.val = sd.e_val;
        endcase
        n_p.use_span = (sd.op == OP_MUL) || (sd.op == OP_DIV);
        n_p.span_ok  = (sd.op == OP_MUL) ? (sd.mul_pre && (ovf == 4'd0)) : sd.div_pre;
        n_p.e_ok     = sd.e_rv && !(sd.e_lo > sd.e_hi);
        n_p.e_lo     = sd.e_lo;
        n_p.e_hi     = sd.e_hi;
        n_p.min01    = (c[0] < c[1]) ? c[0] : c[1];
        n_p.max01    = (c[0] > c[1]) ? c[0] : c[1];
        n_p.min23    = (c[2] < c[3]) ? c[2] : c[3];
        n_p.max23    = (c[2] > c[3]) ? c[2] : c[3];
    end

    always_comb begin
        n_out = '0;
        if (r_p.vk) begin
            n_out.value_known  = 1'b1;
            n_out.result_value = r_p.val;
            n_out.range_valid  = 1'b1;
            n_out.range_min    = r_p.val;
            n_out.range_max    = r_p.val;
        end else if (r_p.use_span) begin
            if (r_p.span_ok) begin
                n_out.range_valid = 1'b1;
                n_out.range_min   = (r_p.min01 < r_p.min23) ? r_p.min01 : r_p.min23;
                n_out.range_max   = (r_p.max01 > r_p.max23) ? r_p.max01 : r_p.max23;
            end
        end else if (r_p.e_ok) begin
            n_out.range_valid = 1'b1;
            n_out.range_min   = r_p.e_lo;
            n_out.range_max   = r_p.e_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in  <= i_data;
            r_sd[0] <= n_sd;
            for (int k = 1; k < CORE_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
            r_p   <= n_p;
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            for (int k = 0; k < CORE_LAT; k++) begin
                r_vl[k] <= 1'b0;
            end
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_iv    <= i_valid;
            r_vl[0] <= r_iv;
            for (int k = 1; k < CORE_LAT; k++) begin
                r_vl[k] <= r_vl[k-1];
            end
            r_pv <= r_vl[CORE_LAT-1];
            r_ov <= r_pv;
        end
    end

    `ICFU_ASSERT_NOW(a_known_pins_range, o_valid && o_data.value_known,
        o_data.range_valid && o_data.range_min == o_data.result_value
        && o_data.range_max == o_data.result_value, "folded constant must pin the range")
    `ICFU_ASSERT_NOW(a_unknown_zero, o_valid && !o_data.value_known,
        o_data.result_value == 64'd0, "result value must be zero when not folded")
    `ICFU_ASSERT_NOW(a_no_range_zero, o_valid && !o_data.range_valid,
        o_data.range_min == 64'd0 && o_data.range_max == 64'd0, "invalid range must be zero")
    `ICFU_ASSERT_NOW(a_range_order, o_valid && o_data.range_valid,
        $signed(o_data.range_min) <= $signed(o_data.range_max), "range bounds out of order")
    `ICFU_ASSERT_NEXT(a_hold_on_stall, r_pv && o_valid && !i_ready,
        r_pv && o_valid, "stall dropped a transaction")

endmodule
`default_nettype wire

// ----- sim/interval_constant_fold_unit_tb.sv -----
// Testbench for interval_constant_fold_unit: directed table plus random transactions,
// each result checked against a hand-written table entry or an in-bench interval folding predictor.
// Depends on icfu_pkg and the RTL of interval_constant_fold_unit.
`default_nettype none
module interval_constant_fold_unit_tb;
    import icfu_pkg::*;

    localparam int LATENCY   = 69;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 750;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;

    interval_constant_fold_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_out fold_expected[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_off = 1'b0;

    function automatic logic signed [63:0] sra64(logic signed [63:0] v, int s);
        sra64 = v >>> s;
    endfunction

    function automatic bit add_chk(logic signed [63:0] a, logic signed [63:0] b,
                                   output logic signed [63:0] r);
        logic signed [64:0] w;
        w = 65'(a) + 65'(b);
        r = w[63:0];
        add_chk = (w[64] == w[63]);
    endfunction

    function automatic bit sub_chk(logic signed [63:0] a, logic signed [63:0] b,
                                   output logic signed [63:0] r);
        logic signed [64:0] w;
        w = 65'(a) - 65'(b);
        r = w[63:0];
        sub_chk = (w[64] == w[63]);
    endfunction

    function automatic bit mul_chk(logic signed [63:0] a, logic signed [63:0] b,
                                   output logic signed [63:0] r);
        logic signed [127:0] w;
        w = 128'(a) * 128'(b);
        r = w[63:0];
        mul_chk = (w[127:63] == {65{w[63]}});
    endfunction

    function automatic bit div_chk(logic signed [63:0] a, logic signed [63:0] b,
                                   output logic signed [63:0] r);
        r = '0;
        if (b == 0 || (a == S64_MIN && b == -64'sd1)) return 1'b0;
        r = a / b;
        return 1'b1;
    endfunction

    function automatic void span_of(logic signed [63:0] c[4],
                                    output logic signed [63:0] lo, hi);
        lo = c[0];
        hi = c[0];
        for (int i = 1; i < 4; i++) begin
            if (c[i] < lo) lo = c[i];
            if (c[i] > hi) hi = c[i];
        end
    endfunction

    function automatic bit fold_const(t_op op, logic signed [63:0] a, logic signed [63:0] b,
                                      output logic signed [63:0] r);
        r = '0;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            OP_DIV: return div_chk(a, b, r);
            OP_MOD: begin
                if (b == 0 || (a == S64_MIN && b == -64'sd1)) return 1'b0;
                r = a % b;
            end
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_SHL: begin
                if (b < 0 || b >= 64) return 1'b0;
                r = a << b[5:0];
            end
            OP_SAR: begin
                if (b < 0 || b >= 64) return 1'b0;
                r = sra64(a, int'(b[5:0]));
            end
            OP_EQ: r = 64'(a == b);
            OP_NE: r = 64'(a != b);
            OP_LT: r = 64'(a < b);
            OP_LE: r = 64'(a <= b);
            OP_GT: r = 64'(a > b);
            default: r = 64'(a >= b);
        endcase
        return 1'b1;
    endfunction

    function automatic bit range_of(t_in d, output logic signed [63:0] rlo, rhi);
        logic signed [63:0] lo, hi, c[4];
        logic [63:0] m;
        bit ok;
        lo = '0;
        hi = '0;
        rlo = '0;
        rhi = '0;
        if (d.opcode == OP_AND) begin
            if (d.b_known && d.b_value >= 0) begin
                rhi = d.b_value;
                return 1'b1;
            end
            if (d.a_known && d.a_value >= 0) begin
                rhi = d.a_value;
                return 1'b1;
            end
        end
        if (!d.a_has_range || !d.b_has_range) return 1'b0;
        case (d.opcode)
            OP_ADD: if (!add_chk(d.a_min, d.b_min, lo) || !add_chk(d.a_max, d.b_max, hi))
                return 1'b0;
            OP_SUB: if (!sub_chk(d.a_min, d.b_max, lo) || !sub_chk(d.a_max, d.b_min, hi))
                return 1'b0;
            OP_MUL: begin
                ok = mul_chk(d.a_min, d.b_min, c[0]) & mul_chk(d.a_min, d.b_max, c[1])
                   & mul_chk(d.a_max, d.b_min, c[2]) & mul_chk(d.a_max, d.b_max, c[3]);
                if (!ok) return 1'b0;
                span_of(c, rlo, rhi);
                return 1'b1;
            end
            OP_DIV: begin
                if (d.b_min <= 0 && d.b_max >= 0) return 1'b0;
                ok = div_chk(d.a_min, d.b_min, c[0]) & div_chk(d.a_min, d.b_max, c[1])
                   & div_chk(d.a_max, d.b_min, c[2]) & div_chk(d.a_max, d.b_max, c[3]);
                if (!ok) return 1'b0;
                span_of(c, rlo, rhi);
                return 1'b1;
            end
            OP_MOD: begin
                if (!d.b_known || d.b_value == 0 || d.b_value == S64_MIN) return 1'b0;
                hi = (d.b_value < 0) ? -d.b_value - 1 : d.b_value - 1;
                lo = (d.a_min < 0) ? -hi : 64'sd0;
                if (d.a_max <= 0) hi = 0;
            end
            OP_SHL: begin
                if (!d.b_known || d.b_value < 0 || d.b_value >= 63 || d.a_min < 0)
                    return 1'b0;
                if (!mul_chk(d.a_min, 64'sd1 << d.b_value[5:0], lo) ||
                    !mul_chk(d.a_max, 64'sd1 << d.b_value[5:0], hi))
                    return 1'b0;
            end
            OP_SAR: begin
                if (!d.b_known || d.b_value < 0 || d.b_value >= 64) return 1'b0;
                lo = sra64(d.a_min, int'(d.b_value[5:0]));
                hi = sra64(d.a_max, int'(d.b_value[5:0]));
            end
            OP_AND, OP_OR, OP_XOR: begin
                if (d.a_min < 0 || d.b_min < 0) return 1'b0;
                m = d.a_max | d.b_max;
                if (d.opcode != OP_AND)
                    for (int i = 62; i >= 0; i--) m[i] = m[i] | m[i+1];
                lo = 0;
                hi = m;
            end
            default: return 1'b0;
        endcase
        if (lo > hi) return 1'b0;
        rlo = lo;
        rhi = hi;
        return 1'b1;
    endfunction

    function automatic t_out predict_fold(t_in d);
        t_out o;
        logic signed [63:0] v, lo, hi;
        o = '0;
        if (d.a_known && d.b_known && fold_const(d.opcode, d.a_value, d.b_value, v)) begin
            o.value_known = 1'b1;
            o.result_value = v;
            o.range_valid = 1'b1;
            o.range_min = v;
            o.range_max = v;
        end else if (d.opcode >= OP_EQ) begin
            o.range_valid = 1'b1;
            o.range_max = 64'sd1;
        end else if (range_of(d, lo, hi)) begin
            o.range_valid = 1'b1;
            o.range_min = lo;
            o.range_max = hi;
        end
        return o;
    endfunction

    function automatic logic signed [63:0] pick64();
        case ($urandom_range(0, 9))
            0: pick64 = S64_MIN + $urandom_range(0, 2);
            1: pick64 = S64_MAX - $urandom_range(0, 2);
            2, 3: pick64 = $signed(64'($urandom_range(0, 40))) - 20;
            4: pick64 = 64'sd1 << $urandom_range(0, 63);
            5: pick64 = $signed(64'($urandom_range(0, 100000)));
            default: pick64 = {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in random_item();
        t_in d;
        logic signed [63:0] x, y;
        d.opcode = t_op'($urandom_range(0, 15));
        d.a_known = $urandom_range(0, 2) != 0;
        d.b_known = $urandom_range(0, 2) != 0;
        d.a_has_range = $urandom_range(0, 4) != 0;
        d.b_has_range = $urandom_range(0, 4) != 0;
        d.a_value = pick64();
        d.b_value = (d.opcode inside {OP_SHL, OP_SAR} && $urandom_range(0, 3) != 0)
                  ? $signed(64'($urandom_range(0, 70))) - 3 : pick64();
        x = pick64();
        y = pick64();
        if ($urandom_range(0, 9) != 0 && x > y) {x, y} = {y, x};
        d.a_min = x;
        d.a_max = y;
        x = pick64();
        y = pick64();
        if ($urandom_range(0, 9) != 0 && x > y) {x, y} = {y, x};
        if ($urandom_range(0, 3) == 0) begin
            x = $signed(64'($urandom_range(1, 50)));
            y = x + $urandom_range(0, 50);
        end
        d.b_min = x;
        d.b_max = y;
        return d;
    endfunction

    typedef struct {
        t_in  d;
        bit   typed;
        t_out o;
    } t_row;

    t_row dir_rows[$];

    function automatic t_in mk(t_op op, bit ak, logic signed [63:0] av, bit ar,
                               logic signed [63:0] al, ah, bit bk,
                               logic signed [63:0] bv, bit br, logic signed [63:0] bl, bh);
        return '{op, ak, av, ar, al, ah, bk, bv, br, bl, bh};
    endfunction

    function automatic t_out res(bit vk, logic signed [63:0] v, bit rv,
                                 logic signed [63:0] lo, hi);
        return '{vk, v, rv, lo, hi};
    endfunction

    task automatic build_table();
        t_out none;
        none = '0;
        dir_rows.push_back('{mk(OP_ADD, 1, S64_MAX, 0, 0, 0, 1, 1, 0, 0, 0), 1,
                             res(1, S64_MIN, 1, S64_MIN, S64_MIN)});
        dir_rows.push_back('{mk(OP_DIV, 1, 5, 0, 0, 0, 1, 0, 0, 0, 0), 1, none});
        dir_rows.push_back('{mk(OP_DIV, 1, S64_MIN, 0, 0, 0, 1, -1, 0, 0, 0), 1, none});
        dir_rows.push_back('{mk(OP_MOD, 1, S64_MIN, 0, 0, 0, 1, -1, 0, 0, 0), 1, none});
        dir_rows.push_back('{mk(OP_SHL, 1, 1, 0, 0, 0, 1, 64, 0, 0, 0), 1, none});
        dir_rows.push_back('{mk(OP_SAR, 1, -1, 0, 0, 0, 1, -1, 0, 0, 0), 1, none});
        dir_rows.push_back('{mk(OP_SHL, 1, 1, 0, 0, 0, 1, 63, 0, 0, 0), 1,
                             res(1, S64_MIN, 1, S64_MIN, S64_MIN)});
        dir_rows.push_back('{mk(OP_LT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                             res(0, 0, 1, 0, 1)});
        dir_rows.push_back('{mk(OP_GE, 1, S64_MIN, 0, 0, 0, 1, S64_MAX, 0, 0, 0), 1,
                             res(1, 0, 1, 0, 0)});
        dir_rows.push_back('{mk(OP_ADD, 0, 0, 1, S64_MAX, S64_MAX, 0, 0, 1, 1, 1), 1,
                             none});
        dir_rows.push_back('{mk(OP_AND, 0, 0, 0, 0, 0, 1, 255, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk(OP_AND, 1, 7, 0, 0, 0, 1, -1, 0, 0, 0), 0, none});
        dir_rows.push_back('{mk(OP_AND, 0, 0, 1, 0, 12, 0, 0, 1, 3, 5), 0, none});
        dir_rows.push_back('{mk(OP_OR, 0, 0, 1, 0, 9, 0, 0, 1, 0, 16), 0, none});
        dir_rows.push_back('{mk(OP_XOR, 0, 0, 1, -1, 9, 0, 0, 1, 0, 16), 0, none});
        dir_rows.push_back('{mk(OP_SUB, 0, 0, 1, -10, 10, 0, 0, 1, -3, 4), 0, none});
        dir_rows.push_back('{mk(OP_MUL, 0, 0, 1, -7, 9, 0, 0, 1, -3, 4), 0, none});
        dir_rows.push_back('{mk(OP_MUL, 0, 0, 1, S64_MIN, 0, 0, 0, 1, -1, 1), 0, none});
        dir_rows.push_back('{mk(OP_DIV, 0, 0, 1, -100, 100, 0, 0, 1, 3, 7), 0, none});
        dir_rows.push_back('{mk(OP_DIV, 0, 0, 1, -100, 100, 0, 0, 1, -3, 7), 0, none});
        dir_rows.push_back('{mk(OP_MOD, 0, 0, 1, -5, 50, 1, -8, 1, 0, 0), 0, none});
        dir_rows.push_back('{mk(OP_MOD, 0, 0, 1, 0, 50, 1, S64_MIN, 1, 0, 0), 0, none});
        dir_rows.push_back('{mk(OP_SHL, 0, 0, 1, 1, 3, 1, 62, 1, 0, 0), 0, none});
        dir_rows.push_back('{mk(OP_SAR, 0, 0, 1, S64_MIN, 40, 1, 63, 1, 0, 0), 0, none});
        dir_rows.push_back('{mk(OP_ADD, 0, 0, 1, 10, 0, 0, 0, 1, 0, 0), 0, none});
    endtask

    task automatic send(t_in d, t_out want);
        i_valid <= 1'b1;
        i_data <= d;
        fold_expected.push_back(want);
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin : sender
        t_row row;
        t_in  d;
        int burst;
        build_table();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send(row.d, row.typed ? row.o : predict_fold(row.d));
        end
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && n < N_RANDOM; j++, n++) begin
                d = random_item();
                send(d, predict_fold(d));
            end
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin : receiver
        int mode;
        @(posedge i_rst_n);
        repeat (40) @(posedge i_clk);
        hold_off = 1'b1;
        i_ready <= 1'b0;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 60)) begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= ($urandom_range(0, 1) != 0);
                    default: i_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (fold_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction: %p", o_data);
            end else begin
                want = fold_expected.pop_front();
                if (o_data.value_known !== want.value_known ||
                    o_data.result_value !== want.result_value ||
                    o_data.range_valid !== want.range_valid ||
                    o_data.range_min !== want.range_min ||
                    o_data.range_max !== want.range_max) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, actual %p", want, o_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || hold_off || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : finisher
        wait (stim_done || idle_cycles >= WDOG_MAX);
        while (fold_expected.size() != 0 && idle_cycles < WDOG_MAX) @(posedge i_clk);
        if (idle_cycles >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
        end else begin
            repeat (LATENCY + 10) @(posedge i_clk);
            if (mismatches == 0 && fold_expected.size() == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
